[rtl/upud_pkg.sv]
`default_nettype none

package upud_pkg;

  // code unit, code point and APB address widths
  localparam int unsigned UNIT_W = 16;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned PADDR_W = 3;

  // register map
  localparam logic REG_PRESERVE = 1'b0;

  // characters of interest
  localparam logic [UNIT_W-1:0] CHAR_PCT = 16'h0025;

  // utf-8 and utf-16 limits
  localparam logic [CP_W-1:0] CP_MIN_2   = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN_3   = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN_4   = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SUR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SUR_HI  = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_PLANE1  = 21'h010000;
  localparam logic [UNIT_W-1:0] SURR_HI_BASE = 16'hD800;
  localparam logic [UNIT_W-1:0] SURR_LO_BASE = 16'hDC00;

  // escape parser phase
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_LEAD_PCT  = 3'd1,
    PH_LEAD_HI   = 3'd2,
    PH_CONT_WAIT = 3'd3,
    PH_CONT_PCT  = 3'd4,
    PH_CONT_HI   = 3'd5
  } upud_phase_e;

  // one decoded step: up to three units for the back end
  typedef struct packed {
    logic [1:0]                   count;
    logic [2:0][UNIT_W-1:0]       units;
    logic                         malformed;
    logic                         eos;
  } upud_cmd_t;

  // hex digit: bit 4 valid, bits 3:0 value
  function automatic logic [4:0] hex_digit(input logic [UNIT_W-1:0] u);
    logic [4:0] r;
    r = 5'd0;
    if (u >= 16'h0030 && u <= 16'h0039) begin
      r = {1'b1, 4'(u - 16'h0030)};
    end else if (u >= 16'h0061 && u <= 16'h0066) begin
      r = {1'b1, 4'(u - 16'h0057)};
    end else if (u >= 16'h0041 && u <= 16'h0046) begin
      r = {1'b1, 4'(u - 16'h0037)};
    end
    return r;
  endfunction

  // reserved set ; , / ? : @ & = + $ #
  function automatic logic is_reserved(input logic [7:0] c);
    logic r;
    unique case (c)
      8'h3B, 8'h2C, 8'h2F, 8'h3F, 8'h3A, 8'h40,
      8'h26, 8'h3D, 8'h2B, 8'h24, 8'h23: r = 1'b1;
      default:                            r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/upud_front.sv]
`default_nettype none

module upud_front
  import upud_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [UNIT_W-1:0] unit_i,
  input  wire logic              last_i,
  input  wire logic              preserve_i,
  output logic                   push_o,
  output upud_cmd_t              cmd_o
);

  upud_phase_e      phase_q, phase_d;
  logic [3:0]       nib_q, nib_d;
  logic [7:0]       held_q, held_d;
  logic [CP_W-1:0]  acc_q, acc_d;
  logic [1:0]       left_q, left_d;
  logic [1:0]       cls_q, cls_d;
  logic             swallow_q, swallow_d;

  logic             bad;
  logic [4:0]       hx;
  logic [7:0]       byte_v;
  logic [CP_W-1:0]  cp;
  logic [CP_W-1:0]  cp_min;
  logic [CP_W-1:0]  cp_off;
  upud_cmd_t        cmd;

  assign hx     = hex_digit(unit_i);
  assign byte_v = {nib_q, hx[3:0]};
  assign cp     = {acc_q[CP_W-7:0], byte_v[5:0]};
  assign cp_off = cp - CP_PLANE1;

  always_comb begin
    unique case (cls_q)
      2'd1:    cp_min = CP_MIN_2;
      2'd2:    cp_min = CP_MIN_3;
      default: cp_min = CP_MIN_4;
    endcase
  end

  // classify the unit and advance the escape parser
  always_comb begin
    phase_d   = phase_q;
    nib_d     = nib_q;
    held_d    = held_q;
    acc_d     = acc_q;
    left_d    = left_q;
    cls_d     = cls_q;
    swallow_d = swallow_q;
    bad       = 1'b0;
    cmd       = '0;

    if (swallow_q) begin
      if (last_i) begin
        swallow_d = 1'b0;
      end
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          if (unit_i == CHAR_PCT) begin
            phase_d = PH_LEAD_PCT;
          end else begin
            cmd.count    = 2'd1;
            cmd.units[0] = unit_i;
          end
        end
        PH_LEAD_PCT, PH_CONT_PCT: begin
          if (!hx[4]) begin
            bad = 1'b1;
          end else begin
            nib_d = hx[3:0];
            if (phase_q == PH_LEAD_PCT) begin
              held_d  = unit_i[7:0];
              phase_d = PH_LEAD_HI;
            end else begin
              phase_d = PH_CONT_HI;
            end
          end
        end
        PH_LEAD_HI: begin
          if (!hx[4]) begin
            bad = 1'b1;
          end else if (!byte_v[7]) begin
            // ascii: maybe keep the escape as written
            if (preserve_i && is_reserved(byte_v)) begin
              cmd.count    = 2'd3;
              cmd.units[0] = CHAR_PCT;
              cmd.units[1] = {8'h00, held_q};
              cmd.units[2] = unit_i;
            end else begin
              cmd.count    = 2'd1;
              cmd.units[0] = {8'h00, byte_v};
            end
            phase_d = PH_IDLE;
          end else if (byte_v[7:5] == 3'b110) begin
            acc_d   = CP_W'(byte_v[4:0]);
            left_d  = 2'd1;
            cls_d   = 2'd1;
            phase_d = PH_CONT_WAIT;
          end else if (byte_v[7:4] == 4'b1110) begin
            acc_d   = CP_W'(byte_v[3:0]);
            left_d  = 2'd2;
            cls_d   = 2'd2;
            phase_d = PH_CONT_WAIT;
          end else if (byte_v[7:3] == 5'b11110) begin
            acc_d   = CP_W'(byte_v[2:0]);
            left_d  = 2'd3;
            cls_d   = 2'd3;
            phase_d = PH_CONT_WAIT;
          end else begin
            bad = 1'b1;
          end
        end
        PH_CONT_WAIT: begin
          if (unit_i == CHAR_PCT) begin
            phase_d = PH_CONT_PCT;
          end else begin
            bad = 1'b1;
          end
        end
        PH_CONT_HI: begin
          if (!hx[4] || byte_v[7:6] != 2'b10) begin
            bad = 1'b1;
          end else begin
            acc_d  = cp;
            left_d = left_q - 2'd1;
            if (left_q != 2'd1) begin
              phase_d = PH_CONT_WAIT;
            end else if (cp < cp_min || cp > CP_MAX ||
                         (cp >= CP_SUR_LO && cp <= CP_SUR_HI)) begin
              bad = 1'b1;
            end else begin
              if (cp < CP_PLANE1) begin
                cmd.count    = 2'd1;
                cmd.units[0] = cp[UNIT_W-1:0];
              end else begin
                cmd.count    = 2'd2;
                cmd.units[0] = SURR_HI_BASE + UNIT_W'(cp_off[19:10]);
                cmd.units[1] = SURR_LO_BASE + UNIT_W'(cp_off[9:0]);
              end
              phase_d = PH_IDLE;
            end
          end
        end
        default: bad = 1'b1;
      endcase

      // a string may not end inside an escape
      if (!bad && last_i && phase_d != PH_IDLE) begin
        bad = 1'b1;
      end

      if (bad) begin
        phase_d       = PH_IDLE;
        nib_d         = '0;
        held_d        = '0;
        acc_d         = '0;
        left_d        = '0;
        cls_d         = '0;
        swallow_d     = !last_i;
        cmd           = '0;
        cmd.count     = 2'd1;
        cmd.malformed = 1'b1;
        cmd.eos       = 1'b1;
      end else begin
        cmd.eos = last_i;
      end
    end
  end

  // parser state, advanced on each accepted unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      nib_q     <= '0;
      held_q    <= '0;
      acc_q     <= '0;
      left_q    <= '0;
      cls_q     <= '0;
      swallow_q <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      nib_q     <= nib_d;
      held_q    <= held_d;
      acc_q     <= acc_d;
      left_q    <= left_d;
      cls_q     <= cls_d;
      swallow_q <= swallow_d;
    end
  end

  assign push_o = accept_i && (cmd.count != 2'd0);
  assign cmd_o  = cmd;

endmodule

`default_nettype wire

[rtl/upud_queue.sv]
`default_nettype none

module upud_queue
  import upud_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  upud_cmd_t  push_data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output upud_cmd_t  head_o,
  output logic       empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  upud_cmd_t          slot_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d;
  logic [PTR_W-1:0]   rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/upud_back.sv]
`default_nettype none

module upud_back
  import upud_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  upud_cmd_t              head_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [UNIT_W-1:0]      unit_o,
  output logic                   malformed_o,
  output logic                   eos_o
);

  logic [1:0] idx_q, idx_d;
  logic       final_unit;
  logic       xfer;

  // walk the units of the head entry one per request
  assign final_unit  = (idx_q == 2'(head_i.count - 2'd1));
  assign valid_o     = !empty_i;
  assign xfer        = valid_o && ready_i;
  assign pop_o       = xfer && final_unit;
  assign unit_o      = head_i.units[idx_q];
  assign malformed_o = head_i.malformed;
  assign eos_o       = head_i.eos && final_unit;

  always_comb begin
    idx_d = idx_q;
    if (xfer) begin
      idx_d = final_unit ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

[rtl/uri_percent_utf8_decoder.sv]
// URI percent decoder: UTF-16 code units in, decoded UTF-16 code units out.
// Input stream s_axis: one code unit per request in tdata, tlast on the final
// unit of a string. Output stream m_axis: one decoded unit per request in
// tdata, tuser on the single result that ends a malformed string, tlast on the
// final result of a string (always set together with tuser).
// APB register 0 (address 0), bit 0: preserve_reserved, reset 0; set it to
// keep escapes of reserved characters as their three original units.
// The front parser takes one unit every cycle while the queue has room and
// writes each step's results (zero to three units) into a QUEUE_DEPTH-entry
// queue; the back end sends one unit per cycle from the queue head while
// m_axis_tready is high. A result waits in the queue until it is at the head.
// Units go in at one per cycle while the queue has room; a step with three
// results takes three transfers, so the output port sets the sustained rate.
// When the receiver stalls, the queue fills and s_axis_tready drops while it
// is full. Reset empties the queue and returns the parser to plain text.
`default_nettype none

module uri_percent_utf8_decoder
  import upud_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [15:0]         s_axis_tdata,   // [15:0] unit
  input  wire logic                s_axis_tlast,
  // output stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [15:0]              m_axis_tdata,   // [15:0] out_unit
  output logic                     m_axis_tuser,   // [0] malformed
  output logic                     m_axis_tlast,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic      preserve_q;
  logic      accept;
  logic      push;
  upud_cmd_t push_cmd;
  logic      full;
  logic      pop;
  upud_cmd_t head;
  logic      empty;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PRESERVE) ? {31'd0, preserve_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preserve_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_PRESERVE) begin
      preserve_q <= pwdata[0];
    end
  end

  // front: parse and classify
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  upud_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .unit_i     (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .preserve_i (preserve_q),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // queue between parser and output
  upud_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  // back: serialize results
  upud_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .unit_o      (m_axis_tdata),
    .malformed_o (m_axis_tuser),
    .eos_o       (m_axis_tlast)
  );

  // checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("queue read while empty");

  a_malformed_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("malformed result not marked as end of string");

endmodule

`default_nettype wire

[verif/tb.sv]
`default_nettype none

module tb;
  import upud_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYC    = 12;
  localparam int SETTLE_CYC   = 6;
  localparam int HOLD_CYC     = 80;
  localparam int RAND_ITEMS   = 500;
  localparam int RAND_PHASES  = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;
  localparam int IDLE_PCT     = 36;
  localparam logic [PADDR_W-1:0] PRESERVE_ADDR = PADDR_W'(4 * int'(REG_PRESERVE));

  // one decoded result as seen on the output stream
  typedef struct packed {
    logic [UNIT_W-1:0] val;
    logic              mal;
    logic              eos;
  } result_t;

  localparam result_t NO_RES  = '0;
  localparam result_t MAL_RES = '{val: 16'h0000, mal: 1'b1, eos: 1'b1};

  // directed stimulus rows
  typedef enum logic [1:0] {
    ROW_TEXT,
    ROW_RAW,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    string             text;
    logic [UNIT_W-1:0] raw;
    logic              last;
    logic              typed;
    result_t           want;
  } stim_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [PADDR_W-1:0]  paddr         = '0;
  logic [31:0]         pwdata        = '0;
  logic [31:0]         prdata;
  logic                pready;

  uri_percent_utf8_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // decoder mirror state
  logic              preserve_mdl = 1'b0;
  upud_phase_e       ph_mdl       = PH_IDLE;
  logic [3:0]        hi_nib       = '0;
  logic [7:0]        held_ch      = '0;
  logic [CP_W-1:0]   cp_acc       = '0;
  logic [1:0]        cont_left    = '0;
  logic [1:0]        len_cls      = '0;
  logic              swallowing   = 1'b0;

  result_t           decoded_q[$];
  logic [UNIT_W-1:0] str_q[$];
  string             rsv_chars = ";,/?:@&=+$#";

  // tag of the unit on the bus, for table rows with a typed result
  logic              drv_typed = 1'b0;
  result_t           drv_want  = '0;

  // idling and stall control
  logic              tx_gap_en = 1'b1;
  logic              rx_gap_en = 1'b1;
  logic              hold_tog  = 1'b0;
  logic              hold_ack  = 1'b0;
  int                hold_left = 0;

  int fail_cnt    = 0;
  int n_units     = 0;
  int n_swallowed = 0;
  int n_strings   = 0;
  int n_results   = 0;
  int n_malformed = 0;
  int bp_cycles   = 0;

  function automatic logic [15:0] asc(input logic [7:0] c);
    return {8'h00, c};
  endfunction

  // bit 4 set when the unit is a hex digit, value below
  function automatic logic [4:0] hex_val(input logic [15:0] u);
    if (u >= asc("0") && u <= asc("9")) return {1'b1, u[3:0]};
    if ((u >= asc("a") && u <= asc("f")) || (u >= asc("A") && u <= asc("F")))
      return {1'b1, u[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic logic is_kept(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < rsv_chars.len(); i++) begin
      if (rsv_chars[i] == c) hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // step the decoder mirror by one unit, queue the decoded results
  task automatic decode_unit(input logic [15:0] u, input logic l);
    result_t         outs[$];
    logic            bad;
    logic [4:0]      hx;
    logic [7:0]      b;
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] v;
    bad = 1'b0;
    if (swallowing) begin
      n_swallowed++;
      if (l) swallowing = 1'b0;
      return;
    end
    hx = hex_val(u);
    case (ph_mdl)
      PH_IDLE: begin
        if (u == CHAR_PCT) ph_mdl = PH_LEAD_PCT;
        else outs.insert(outs.size(), '{u, 1'b0, 1'b0});
      end
      PH_LEAD_PCT, PH_CONT_PCT: begin
        if (!hx[4]) begin
          bad = 1'b1;
        end else begin
          hi_nib = hx[3:0];
          if (ph_mdl == PH_LEAD_PCT) begin
            held_ch = u[7:0];
            ph_mdl  = PH_LEAD_HI;
          end else begin
            ph_mdl = PH_CONT_HI;
          end
        end
      end
      PH_LEAD_HI: begin
        b = {hi_nib, hx[3:0]};
        if (!hx[4]) begin
          bad = 1'b1;
        end else if (!b[7]) begin
          if (preserve_mdl && is_kept(b)) begin
            outs.insert(outs.size(), '{CHAR_PCT, 1'b0, 1'b0});
            outs.insert(outs.size(), '{asc(held_ch), 1'b0, 1'b0});
            outs.insert(outs.size(), '{u, 1'b0, 1'b0});
          end else begin
            outs.insert(outs.size(), '{asc(b), 1'b0, 1'b0});
          end
          ph_mdl = PH_IDLE;
        end else if (b[7:5] == 3'b110) begin
          cp_acc = CP_W'(b[4:0]); cont_left = 2'd1; len_cls = 2'd1; ph_mdl = PH_CONT_WAIT;
        end else if (b[7:4] == 4'b1110) begin
          cp_acc = CP_W'(b[3:0]); cont_left = 2'd2; len_cls = 2'd2; ph_mdl = PH_CONT_WAIT;
        end else if (b[7:3] == 5'b11110) begin
          cp_acc = CP_W'(b[2:0]); cont_left = 2'd3; len_cls = 2'd3; ph_mdl = PH_CONT_WAIT;
        end else begin
          bad = 1'b1;
        end
      end
      PH_CONT_WAIT: begin
        if (u == CHAR_PCT) ph_mdl = PH_CONT_PCT;
        else bad = 1'b1;
      end
      PH_CONT_HI: begin
        b = {hi_nib, hx[3:0]};
        if (!hx[4] || b[7:6] != 2'b10) begin
          bad = 1'b1;
        end else begin
          cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
          cont_left = cont_left - 2'd1;
          if (cont_left != 0) begin
            ph_mdl = PH_CONT_WAIT;
          end else begin
            lo = (len_cls == 2'd1) ? CP_MIN_2 : (len_cls == 2'd2) ? CP_MIN_3 : CP_MIN_4;
            if (cp_acc < lo || cp_acc > CP_MAX ||
                (cp_acc >= CP_SUR_LO && cp_acc <= CP_SUR_HI)) begin
              bad = 1'b1;
            end else if (cp_acc < CP_PLANE1) begin
              outs.insert(outs.size(), '{cp_acc[15:0], 1'b0, 1'b0});
            end else begin
              // split into a surrogate pair
              v = cp_acc - CP_PLANE1;
              outs.insert(outs.size(), '{SURR_HI_BASE + {6'd0, v[19:10]}, 1'b0, 1'b0});
              outs.insert(outs.size(), '{SURR_LO_BASE + {6'd0, v[9:0]}, 1'b0, 1'b0});
            end
            ph_mdl = PH_IDLE;
          end
        end
      end
      default: bad = 1'b1;
    endcase

    // unfinished escape on the last unit
    if (!bad && l && ph_mdl != PH_IDLE) bad = 1'b1;

    if (bad) begin
      ph_mdl = PH_IDLE; hi_nib = '0; held_ch = '0; cp_acc = '0; cont_left = '0; len_cls = '0;
      swallowing = !l;
      decoded_q.insert(decoded_q.size(), MAL_RES);
      return;
    end
    if (l && outs.size() > 0) outs[outs.size()-1].eos = 1'b1;
    foreach (outs[i]) decoded_q.insert(decoded_q.size(), outs[i]);
  endtask

  // output check, then prediction for the accepted input request
  always @(posedge clk_i) begin : monitor
    result_t got;
    result_t want;
    int      n0;
    if (rst_ni) begin
      if (s_axis_tvalid && !s_axis_tready) bp_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
        n_results++;
        if (got.mal) n_malformed++;
        if (decoded_q.size() == 0) begin
          note_fail($sformatf("unexpected result unit %h malformed %b last %b",
                              got.val, got.mal, got.eos));
        end else begin
          want = decoded_q.pop_front();
          if (got.val !== want.val || got.mal !== want.mal || got.eos !== want.eos)
            note_fail($sformatf("result %0d: expected %h/%b/%b, got %h/%b/%b", n_results,
                                want.val, want.mal, want.eos, got.val, got.mal, got.eos));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        n0 = decoded_q.size();
        decode_unit(s_axis_tdata, s_axis_tlast);
        if (drv_typed && (decoded_q.size() != n0 + 1 ||
                          decoded_q[decoded_q.size()-1] != drv_want))
          note_fail($sformatf("table result for unit %h: expected %h/%b/%b, %0d predicted",
                              s_axis_tdata, drv_want.val, drv_want.mal, drv_want.eos,
                              decoded_q.size() - n0));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_tog != hold_ack) begin
      hold_ack      <= hold_tog;
      hold_left     <= HOLD_CYC;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(rx_gap_en && $urandom_range(99) < IDLE_PCT);
    end
  end

  // offer one unit and wait for its request to be taken
  task automatic send_unit(input logic [15:0] u, input logic l, input logic typed,
                           input result_t want);
    if (tx_gap_en) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= u;
    s_axis_tlast  <= l;
    drv_typed     <= typed;
    drv_want      <= want;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_units++;
  endtask

  // stop offering and let every queued result come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [PADDR_W-1:0] a, input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (a == PRESERVE_ADDR) preserve_mdl = d[0];
  endtask

  // escape helpers for the random strings
  function automatic logic [15:0] hex_unit(input logic [3:0] nib);
    if (nib < 4'd10) return asc("0") + 16'(nib);
    return (($urandom_range(1) != 0) ? asc("A") : asc("a")) + 16'(nib - 4'd10);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    str_q.insert(str_q.size(), CHAR_PCT);
    str_q.insert(str_q.size(), hex_unit(b[7:4]));
    str_q.insert(str_q.size(), hex_unit(b[3:0]));
  endtask

  task automatic push_cp(input logic [CP_W-1:0] cp, input int len);
    case (len)
      2: begin
        push_byte({3'b110, cp[10:6]});
      end
      3: begin
        push_byte({4'b1110, cp[15:12]});
        push_byte({2'b10, cp[11:6]});
      end
      default: begin
        push_byte({5'b11110, cp[20:18]});
        push_byte({2'b10, cp[17:12]});
        push_byte({2'b10, cp[11:6]});
      end
    endcase
    push_byte({2'b10, cp[5:0]});
  endtask

  function automatic int natural_len(input logic [CP_W-1:0] cp);
    if (cp < CP_MIN_3) return 2;
    if (cp < CP_MIN_4) return 3;
    return 4;
  endfunction

  // build one string of random tokens into str_q
  task automatic build_string(input logic broken);
    int              ntok;
    int              kind;
    int              idx;
    logic [CP_W-1:0] cp;
    logic [7:0]      b;
    logic [15:0]     u;
    str_q.delete();
    ntok = $urandom_range(1, 6);
    for (int t = 0; t < ntok; t++) begin
      kind = $urandom_range(9);
      case (kind)
        0, 1, 2: begin
          if ($urandom_range(1) != 0) u = 16'($urandom);
          else u = 16'($urandom_range(16'h0020, 16'h007E));
          if (!broken && u == CHAR_PCT) u = asc("A");
          str_q.insert(str_q.size(), u);
        end
        3: push_byte(8'($urandom_range(8'h7F)));
        4: push_byte(rsv_chars[$urandom_range(rsv_chars.len() - 1)]);
        5: push_cp(CP_W'($urandom_range(16'h0080, 16'h07FF)), 2);
        6: begin
          cp = CP_W'($urandom_range(16'h0800, 16'hFFFF));
          if (!broken && cp >= CP_SUR_LO && cp <= CP_SUR_HI) cp = cp ^ 21'h002000;
          push_cp(cp, 3);
        end
        7: push_cp(CP_W'($urandom_range(21'h010000, 21'h10FFFF)), 4);
        8: begin
          // values next to the range edges
          case ($urandom_range(7))
            0: cp = 21'h000080;
            1: cp = 21'h0007FF;
            2: cp = 21'h000800;
            3: cp = 21'h00D7FF;
            4: cp = 21'h00E000;
            5: cp = 21'h00FFFF;
            6: cp = 21'h010000;
            default: cp = CP_MAX;
          endcase
          push_cp(cp, natural_len(cp));
        end
        default: begin
          if (!broken) begin
            push_byte(8'($urandom_range(8'h7F)));
          end else begin
            case ($urandom_range(4))
              // overlong form
              0: begin
                idx = $urandom_range(2, 4);
                cp  = (idx == 2) ? CP_W'($urandom_range(8'h7F))
                    : (idx == 3) ? CP_W'($urandom_range(16'h07FF))
                    : CP_W'($urandom_range(16'hFFFF));
                push_cp(cp, idx);
              end
              // surrogate half
              1: push_cp(CP_W'($urandom_range(16'hD800, 16'hDFFF)), 3);
              // beyond the last plane
              2: push_cp(CP_W'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
              // lead byte out of range
              3: begin
                if ($urandom_range(1) != 0) b = 8'($urandom_range(8'h80, 8'hBF));
                else b = 8'($urandom_range(8'hF8, 8'hFF));
                push_byte(b);
                push_byte(8'h80);
              end
              // continuation without the 10 prefix
              default: begin
                push_byte({3'b110, 5'($urandom)});
                b = 8'($urandom);
                if (b[7:6] == 2'b10) b[6] = 1'b1;
                push_byte(b);
              end
            endcase
          end
        end
      endcase
    end
    // broken strings: cut short or hit with noise
    if (broken && $urandom_range(1) != 0) begin
      if (str_q.size() > 1 && $urandom_range(1) != 0) begin
        str_q.pop_back();
      end else begin
        idx = $urandom_range(str_q.size() - 1);
        case ($urandom_range(3))
          0: str_q[idx] = 16'($urandom);
          1: str_q[idx] = CHAR_PCT;
          2: str_q[idx] = asc("G");
          default: str_q[idx] = hex_unit(4'($urandom));
        endcase
      end
    end
  endtask

  function automatic stim_row_t mk_row(input row_kind_e kind, input string text,
                                       input logic [15:0] raw, input logic last,
                                       input logic typed, input result_t want);
    stim_row_t r;
    r.kind  = kind;
    r.text  = text;
    r.raw   = raw;
    r.last  = last;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // watchdog
  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cyc, decoded_q.size());
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    stim_row_t tab[$];
    int        base;
    logic      paused;
    logic      l;
    paused = 1'b0;

    // directed rows: text is sent unit by unit, typed results sit on the final unit
    tab.insert(tab.size(), mk_row(ROW_CFG,  "", 16'h0000, 1'b0, 1'b0, NO_RES));
    tab.insert(tab.size(), mk_row(ROW_RAW,  "", 16'hFFFF, 1'b0, 1'b0, NO_RES));
    tab.insert(tab.size(),
               mk_row(ROW_RAW,  "", 16'h0000, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1}));
    // non-hex digit after the percent sign
    tab.insert(tab.size(), mk_row(ROW_TEXT, "%g", 16'h0, 1'b1, 1'b1, MAL_RES));
    // lead byte out of range, then the rest of the string is dropped
    tab.insert(tab.size(), mk_row(ROW_TEXT, "%F8", 16'h0, 1'b0, 1'b1, MAL_RES));
    tab.insert(tab.size(), mk_row(ROW_TEXT, "q%", 16'h0, 1'b1, 1'b0, NO_RES));
    // no percent sign where a continuation should start
    tab.insert(tab.size(), mk_row(ROW_TEXT, "%E2x", 16'h0, 1'b1, 1'b1, MAL_RES));
    // continuation byte without the 10 prefix
    tab.insert(tab.size(), mk_row(ROW_TEXT, "%c3%41", 16'h0, 1'b1, 1'b1, MAL_RES));
    // overlong two-byte form
    tab.insert(tab.size(), mk_row(ROW_TEXT, "%C0%80", 16'h0, 1'b1, 1'b1, MAL_RES));
    // encoded surrogate half
    tab.insert(tab.size(), mk_row(ROW_TEXT, "%ed%a0%80", 16'h0, 1'b1, 1'b1, MAL_RES));
    // beyond the last plane
    tab.insert(tab.size(), mk_row(ROW_TEXT, "%F4%90%80%80", 16'h0, 1'b1, 1'b1, MAL_RES));
    // string ends inside an escape
    tab.insert(tab.size(), mk_row(ROW_TEXT, "%4", 16'h0, 1'b1, 1'b1, MAL_RES));
    // preserve mode: reserved kept as three units, others decoded
    tab.insert(tab.size(), mk_row(ROW_CFG,  "", 16'h0001, 1'b0, 1'b0, NO_RES));
    tab.insert(tab.size(), mk_row(ROW_TEXT, "%2f", 16'h0, 1'b1, 1'b0, NO_RES));
    tab.insert(tab.size(),
               mk_row(ROW_TEXT, "%41", 16'h0, 1'b1, 1'b1, '{16'h0041, 1'b0, 1'b1}));
    tab.insert(tab.size(), mk_row(ROW_CFG,  "", 16'h0000, 1'b0, 1'b0, NO_RES));
    tab.insert(tab.size(),
               mk_row(ROW_TEXT, "%2F", 16'h0, 1'b1, 1'b1, '{16'h002F, 1'b0, 1'b1}));

    repeat (RESET_CYC) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (tab[i]) begin
      case (tab[i].kind)
        ROW_CFG: begin
          wait_drained();
          reg_write(PRESERVE_ADDR, {31'd0, tab[i].raw[0]});
        end
        ROW_RAW: send_unit(tab[i].raw, tab[i].last, tab[i].typed, tab[i].want);
        default: begin
          for (int k = 0; k < tab[i].text.len(); k++) begin
            l = (k == tab[i].text.len() - 1);
            send_unit(asc(tab[i].text[k]), tab[i].last && l, tab[i].typed && l, tab[i].want);
          end
        end
      endcase
      if (tab[i].kind != ROW_CFG && tab[i].last) n_strings++;
    end
    wait_drained();

    // random part: preserve setting alternates by phase, idle modes vary by phase
    for (int p = 0; p < RAND_PHASES; p++) begin
      reg_write(PRESERVE_ADDR, (p % 2 == 0) ? 32'd1 : 32'd0);
      tx_gap_en = (p != 1 && p != 2);
      rx_gap_en <= (p != 1 && p != 2);
      if (p == 2) hold_tog <= ~hold_tog;
      base = n_units - n_swallowed;
      while (n_units - n_swallowed - base < RAND_ITEMS / RAND_PHASES) begin
        if (p == 3 && !paused && n_units - n_swallowed - base >= RAND_ITEMS / 12) begin
          wait_drained();
          paused = 1'b1;
        end
        build_string($urandom_range(99) < 25);
        foreach (str_q[k]) send_unit(str_q[k], k == str_q.size() - 1, 1'b0, NO_RES);
        n_strings++;
      end
      wait_drained();
    end

    $display("run: %0d units in %0d strings, %0d results checked, %0d malformed",
             n_units, n_strings, n_results, n_malformed);
    $display("run: preserve mode on and off, %0d cycles of input back-pressure", bp_cycles);
    if (fail_cnt == 0 && decoded_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results left over", fail_cnt, decoded_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/upud_pkg.sv
rtl/upud_front.sv
rtl/upud_queue.sv
rtl/upud_back.sv
rtl/uri_percent_utf8_decoder.sv
verif/tb.sv
